[rtl/core/wrwk_pkg.sv]
// ----------------------------------------------------------------------------
// wrwk_pkg
// Shared types and constants of the weighted random walk step block.
// ----------------------------------------------------------------------------
package wrwk_pkg;

  // table geometry and field widths
  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned VERTEX_W     = 4;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned COLUMN_W     = 5;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned TOTAL_W      = 20;
  localparam int unsigned FRACTION_W   = 16;
  localparam int unsigned EDGE_ADDR_W  = 2 * VERTEX_W;
  localparam int unsigned LHS_W        = TOTAL_W + FRACTION_W;
  localparam int unsigned REM_W        = TOTAL_W + 1;
  localparam int unsigned MIN_VERTICES = 2;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_VERTEX = 1'd1;

  // register reset values
  localparam logic [COUNT_W-1:0]  COUNT_RESET = 5'd16;
  localparam logic [VERTEX_W-1:0] START_RESET = 4'd0;

  // item commands
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // input item
  typedef struct packed {
    logic [1:0]            cmd;
    logic [VERTEX_W-1:0]   row;
    logic [COLUMN_W-1:0]   column;
    logic [TOTAL_W-1:0]    weight;
    logic [FRACTION_W-1:0] random_fraction;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [VERTEX_W-1:0] next_vertex;
    logic                absorbed;
    logic                self_loop;
    logic                walk_over;
    logic                scan_underflow;
  } out_item_t;

  // configuration write
  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // scan datapath control and status
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic neg;
    logic above;
  } scan_stat_t;

endpackage

[rtl/core/wrwk_chan_if.sv]
// ----------------------------------------------------------------------------
// wrwk_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface wrwk_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/core/wrwk_scan.sv]
// ----------------------------------------------------------------------------
// wrwk_scan
// Remaining-mass datapath of the row scan: holds fraction times total and
// the row total minus the weights scanned so far, and compares them exactly.
// ----------------------------------------------------------------------------
module wrwk_scan (
  input  logic                             clk_i,
  input  wrwk_pkg::scan_ctrl_t             ctrl_i,
  input  logic [wrwk_pkg::TOTAL_W-1:0]     total_i,
  input  logic [wrwk_pkg::FRACTION_W-1:0]  frac_i,
  input  logic [wrwk_pkg::WEIGHT_W-1:0]    weight_i,
  output wrwk_pkg::scan_stat_t             stat_o
);

  logic [wrwk_pkg::LHS_W-1:0] lhs_q;
  logic [wrwk_pkg::REM_W-1:0] rem_q;
  logic [wrwk_pkg::REM_W-1:0] rem_nxt;
  logic [wrwk_pkg::LHS_W-1:0] mass;

  // remaining mass after taking the current weight, two's complement
  assign rem_nxt = rem_q - wrwk_pkg::REM_W'(weight_i);

  // remaining mass scaled by the fraction range
  assign mass = {rem_nxt[wrwk_pkg::TOTAL_W-1:0], wrwk_pkg::FRACTION_W'(0)};

  // stop when the mass goes negative or the fraction lies above it
  assign stat_o.neg   = rem_nxt[wrwk_pkg::REM_W-1];
  assign stat_o.above = !rem_nxt[wrwk_pkg::REM_W-1] && (lhs_q > mass);

  // product is registered before the scan uses it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      lhs_q <= wrwk_pkg::LHS_W'(frac_i) * wrwk_pkg::LHS_W'(total_i);
      rem_q <= wrwk_pkg::REM_W'(total_i);
    end else if (ctrl_i.step) begin
      rem_q <= rem_nxt;
    end
  end

endmodule

[rtl/core/weighted_graph_random_walk_step.sv]
// ----------------------------------------------------------------------------
// weighted_graph_random_walk_step
// Weighted random walk over a stored adjacency table, one step per item,
// with inverse-CDF sampling done by exact cross-multiplication.
//
//   channel  dir  payload                                         transaction
//   in_i     in   cmd, row, column, weight, random_fraction       valid & ready
//   out_o    out  next_vertex, absorbed, self_loop, walk_over,    valid & ready
//                 scan_underflow
//   cfg_i    in   addr (0 vertex_count, 1 start_vertex), data     valid & ready
//
// Write and restart items act at acceptance and leave the input ready. A step
// item goes through ST_MUL, then ST_SCAN for k weights, then ST_DONE, which
// loads its result into the output register; k (1 to the clamped vertex count)
// is the number of weights scanned: the edge memory is read one word a cycle
// down the row. A step from a vertex with zero total skips ST_SCAN.
// The input is taken again once the result sits in the output register;
// a stalled output holds only the next step at its final cycle.
// Reset clears control state alone; the tables need no clearing pass.
// ----------------------------------------------------------------------------
module weighted_graph_random_walk_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  wrwk_chan_if.sink   in_i,
  wrwk_chan_if.source out_o,
  wrwk_chan_if.sink   cfg_i
);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int unsigned EDGE_DEPTH = wrwk_pkg::MAX_VERTICES * wrwk_pkg::MAX_VERTICES;

  logic [1:0]                        state_q, state_d;
  logic [wrwk_pkg::VERTEX_W-1:0]     cur_q, cur_d;
  logic [wrwk_pkg::VERTEX_W-1:0]     j_q, j_d;
  logic                              under_q, under_d;
  logic                              dead_q, dead_d;
  logic [wrwk_pkg::FRACTION_W-1:0]   frac_q, frac_d;
  logic [wrwk_pkg::COUNT_W-1:0]      vcount_q;
  logic [wrwk_pkg::VERTEX_W-1:0]     start_q;

  logic [wrwk_pkg::COUNT_W-1:0]      n_act;
  logic [wrwk_pkg::VERTEX_W-1:0]     last_idx;

  logic                              in_acc;
  logic                              cfg_acc;
  logic                              out_load;
  logic                              out_valid_q;
  wrwk_pkg::out_item_t               out_q;
  wrwk_pkg::out_item_t               res;

  // table memories
  logic [wrwk_pkg::WEIGHT_W-1:0]     edge_mem [EDGE_DEPTH];
  logic [wrwk_pkg::TOTAL_W-1:0]      tot_mem  [wrwk_pkg::MAX_VERTICES];
  logic                              edge_we, edge_re;
  logic                              tot_we, tot_re;
  logic [wrwk_pkg::EDGE_ADDR_W-1:0]  edge_waddr, edge_raddr;
  logic [wrwk_pkg::VERTEX_W-1:0]     tot_raddr;
  logic [wrwk_pkg::WEIGHT_W-1:0]     edge_rdata_q;
  logic [wrwk_pkg::TOTAL_W-1:0]      tot_rdata_q;

  wrwk_pkg::scan_ctrl_t              scan_ctrl;
  wrwk_pkg::scan_stat_t              scan_stat;

  // handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  // vertex count clamped to the table size
  always_comb begin
    if (vcount_q < wrwk_pkg::COUNT_W'(wrwk_pkg::MIN_VERTICES)) begin
      n_act = wrwk_pkg::COUNT_W'(wrwk_pkg::MIN_VERTICES);
    end else if (vcount_q > wrwk_pkg::COUNT_W'(wrwk_pkg::MAX_VERTICES)) begin
      n_act = wrwk_pkg::COUNT_W'(wrwk_pkg::MAX_VERTICES);
    end else begin
      n_act = vcount_q;
    end
  end

  assign last_idx   = wrwk_pkg::VERTEX_W'(n_act - wrwk_pkg::COUNT_W'(1));
  assign edge_waddr = {in_i.payload.row, in_i.payload.column[wrwk_pkg::VERTEX_W-1:0]};

  // step sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    j_d        = j_q;
    under_d    = under_q;
    dead_d     = dead_q;
    frac_d     = frac_q;
    edge_we    = 1'b0;
    tot_we     = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = {cur_q, j_q};
    tot_re     = 1'b0;
    tot_raddr  = cur_q;
    scan_ctrl  = '0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.payload.cmd)
            wrwk_pkg::CMD_WRITE: begin
              if (in_i.payload.column < wrwk_pkg::COLUMN_W'(wrwk_pkg::MAX_VERTICES)) begin
                edge_we = 1'b1;
              end else if (in_i.payload.column ==
                           wrwk_pkg::COLUMN_W'(wrwk_pkg::MAX_VERTICES)) begin
                tot_we = 1'b1;
              end
            end
            wrwk_pkg::CMD_STEP: begin
              frac_d     = in_i.payload.random_fraction;
              tot_re     = 1'b1;
              tot_raddr  = cur_q;
              edge_re    = 1'b1;
              edge_raddr = {cur_q, last_idx};
              j_d        = last_idx;
              under_d    = 1'b0;
              dead_d     = 1'b0;
              state_d    = ST_MUL;
            end
            wrwk_pkg::CMD_RESTART: begin
              cur_d = start_q;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        // zero total: walk stays put, the read total still shows zero
        if (tot_rdata_q == '0) begin
          dead_d  = 1'b1;
          j_d     = cur_q;
          state_d = ST_DONE;
        end else begin
          scan_ctrl.load = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_stat.neg || scan_stat.above) begin
          tot_re    = 1'b1;
          tot_raddr = j_q;
          state_d   = ST_DONE;
        end else if (j_q == '0) begin
          under_d   = 1'b1;
          tot_re    = 1'b1;
          tot_raddr = j_q;
          state_d   = ST_DONE;
        end else begin
          j_d        = j_q - wrwk_pkg::VERTEX_W'(1);
          edge_re    = 1'b1;
          edge_raddr = {cur_q, j_q - wrwk_pkg::VERTEX_W'(1)};
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          cur_d    = j_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // edge weight memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= in_i.payload.weight[wrwk_pkg::WEIGHT_W-1:0];
    end
    if (edge_re) begin
      edge_rdata_q <= edge_mem[edge_raddr];
    end
  end

  // row total memory
  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[in_i.payload.row] <= in_i.payload.weight;
    end
    if (tot_re) begin
      tot_rdata_q <= tot_mem[tot_raddr];
    end
  end

  // remaining-mass datapath
  wrwk_scan u_scan (
    .clk_i    (clk_i),
    .ctrl_i   (scan_ctrl),
    .total_i  (tot_rdata_q),
    .frac_i   (frac_q),
    .weight_i (edge_rdata_q),
    .stat_o   (scan_stat)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= wrwk_pkg::START_RESET;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  // step working registers
  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    under_q <= under_d;
    dead_q  <= dead_d;
    frac_q  <= frac_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= wrwk_pkg::COUNT_RESET;
      start_q  <= wrwk_pkg::START_RESET;
    end else if (cfg_acc) begin
      case (cfg_i.payload.addr)
        wrwk_pkg::CFG_VERTEX_COUNT: vcount_q <= cfg_i.payload.data;
        wrwk_pkg::CFG_START_VERTEX: start_q  <= cfg_i.payload.data[wrwk_pkg::VERTEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res.next_vertex    = j_q;
    res.absorbed       = !dead_q && (j_q == last_idx);
    res.self_loop      = !dead_q && (j_q == cur_q);
    res.walk_over      = (tot_rdata_q == '0);
    res.scan_underflow = under_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef ASSERT_OFF
  // the scan index never leaves the active vertex range
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (j_q <= last_idx))
    else $error("scan index beyond active vertex count");

  // a step item blocks further input while it runs
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.payload.cmd == wrwk_pkg::CMD_STEP)) |=> !in_i.ready)
    else $error("input taken during a step");

  // underflow always lands on vertex zero
  a_under_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scan_underflow) |-> (out_q.next_vertex == '0))
    else $error("scan underflow with non-zero vertex");

  // the walk position moves only at a step end or a restart
  a_cur_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cur_q) |-> ($past(state_q == ST_DONE) ||
                         $past(in_acc && (in_i.payload.cmd == wrwk_pkg::CMD_RESTART))))
    else $error("current vertex changed outside step end or restart");
`endif

endmodule

[tb/sv/weighted_graph_random_walk_step_tb.sv]
// ----------------------------------------------------------------------------
// weighted_graph_random_walk_step_tb
// Self-checking bench for the weighted random walk step block. A plan of
// table writes, restarts, walk steps and register writes feeds a valid/ready
// driver. A monitor tracks the table, the registers and the walk position
// from every accepted transaction, predicts each step result and compares it
// field by field with what the block returns. Both sides idle in random
// bursts, and the bench drains the block before every register write.
// ----------------------------------------------------------------------------
module weighted_graph_random_walk_step_tb;

  import wrwk_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         CALM_OPS      = 80;
  localparam int         PHASES        = 9;
  localparam int         PHASE_ITEMS   = 55;
  localparam int         LIMIT_TIME    = 2_000_000;

  typedef enum logic [1:0] {
    PLAN_ITEM,
    PLAN_CFG,
    PLAN_DRAIN
  } plan_kind_e;

  typedef struct {
    plan_kind_e kind;
    in_item_t   item;
    cfg_item_t  cfg;
  } plan_op_t;

  logic clk_i;
  logic rst_ni;

  wrwk_chan_if #(.payload_t(in_item_t))  in_ch  ();
  wrwk_chan_if #(.payload_t(out_item_t)) out_ch ();
  wrwk_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  weighted_graph_random_walk_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // stimulus plan and the weights it has written so far
  plan_op_t    plan_q[$];
  int unsigned plan_weight [MAX_VERTICES][MAX_VERTICES];

  // walk tracker: table, registers, position and pending step results
  logic [WEIGHT_W-1:0] link_weight [MAX_VERTICES][MAX_VERTICES];
  logic [TOTAL_W-1:0]  row_total [MAX_VERTICES];
  logic [COUNT_W-1:0]  reg_count;
  logic [VERTEX_W-1:0] reg_start;
  logic [VERTEX_W-1:0] walk_at;
  out_item_t           step_result_q[$];

  int results_due;
  int fault_cnt;
  bit calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // plan building
  // ------------------------------------------------------------------------

  function automatic void push_item(logic [1:0] c, logic [VERTEX_W-1:0] r,
                                    logic [COLUMN_W-1:0] col, logic [TOTAL_W-1:0] w,
                                    logic [FRACTION_W-1:0] f);
    plan_op_t op;
    op.kind = PLAN_ITEM;
    op.cfg  = '0;
    op.item.cmd             = c;
    op.item.row             = r;
    op.item.column          = col;
    op.item.weight          = w;
    op.item.random_fraction = f;
    if (c == CMD_WRITE && col < MAX_VERTICES)
      plan_weight[r][col[VERTEX_W-1:0]] = w[WEIGHT_W-1:0];
    plan_q.push_back(op);
  endfunction

  function automatic void push_cfg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    plan_op_t op;
    op.kind     = PLAN_CFG;
    op.item     = '0;
    op.cfg.addr = a;
    op.cfg.data = d;
    plan_q.push_back(op);
  endfunction

  // sender holds off until every result is back and the block has gone quiet
  function automatic void push_pause();
    plan_op_t op;
    op.kind = PLAN_DRAIN;
    op.item = '0;
    op.cfg  = '0;
    plan_q.push_back(op);
  endfunction

  // edge weight with plenty of zeros and full-scale values
  function automatic logic [WEIGHT_W-1:0] plan_edge();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return '0;
    if (sel < 35) return '1;
    return WEIGHT_W'($urandom);
  endfunction

  // row total: mostly the exact row sum, else slack, overweight, dead or noise
  function automatic logic [TOTAL_W-1:0] plan_total(int r, int n);
    int unsigned sum;
    int          sel;
    sum = 0;
    for (int j = 0; j < n; j++) sum += plan_weight[r][j];
    sel = $urandom_range(0, 99);
    if (sel < 50) return TOTAL_W'(sum);
    if (sel < 70) return TOTAL_W'(sum + $urandom_range(1, sum / 8 + 1));
    if (sel < 85) return (sum == 0) ? '0 : TOTAL_W'($urandom_range(0, sum - 1));
    if (sel < 93) return '0;
    return TOTAL_W'($urandom);
  endfunction

  // ------------------------------------------------------------------------
  // walk tracker
  // ------------------------------------------------------------------------

  function automatic void advance_walk(input in_item_t it);
    int unsigned         span;
    logic [VERTEX_W-1:0] from;
    logic [VERTEX_W-1:0] pick;
    logic [TOTAL_W-1:0]  total;
    longint              lhs;
    longint              rem;
    bit                  stop;
    bit                  under;
    out_item_t           res;

    span = (reg_count < MIN_VERTICES) ? MIN_VERTICES :
           (reg_count > MAX_VERTICES) ? MAX_VERTICES : reg_count;
    case (it.cmd)
      CMD_WRITE: begin
        if (it.column < MAX_VERTICES)
          link_weight[it.row][it.column[VERTEX_W-1:0]] = it.weight[WEIGHT_W-1:0];
        else if (it.column == MAX_VERTICES)
          row_total[it.row] = it.weight;
      end
      CMD_RESTART: begin
        walk_at = reg_start;
      end
      CMD_STEP: begin
        from  = walk_at;
        total = row_total[from];
        res   = '0;
        if (total == '0) begin
          // dead vertex: the walk stays put
          res.next_vertex = from;
          res.walk_over   = 1'b1;
        end else begin
          // scan down the row, x <= (T - S) / T done as x * T <= (T - S) << F
          lhs   = longint'(it.random_fraction) * longint'(total);
          rem   = longint'(total);
          stop  = 1'b0;
          under = 1'b0;
          pick  = '0;
          for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (!stop && k < span) begin
              pick = VERTEX_W'(k);
              rem -= longint'(link_weight[from][k]);
              if (rem < 0) stop = 1'b1;
              else if (lhs > (rem << FRACTION_W)) stop = 1'b1;
              else if (k == 0) begin
                under = 1'b1;
                stop  = 1'b1;
              end
            end
          end
          res.next_vertex    = pick;
          res.absorbed       = (pick == span - 1);
          res.self_loop      = (pick == from);
          res.walk_over      = (row_total[pick] == '0);
          res.scan_underflow = under;
          walk_at = pick;
        end
        step_result_q.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_fault(string what, out_item_t want, out_item_t got);
    if (fault_cnt < 10)
      $display("[%0t] %s: expected vertex %0d abs %0b loop %0b over %0b under %0b,",
               $time, what, want.next_vertex, want.absorbed, want.self_loop,
               want.walk_over, want.scan_underflow,
               "  got vertex %0d abs %0b loop %0b over %0b under %0b",
               got.next_vertex, got.absorbed, got.self_loop, got.walk_over,
               got.scan_underflow);
    fault_cnt++;
  endfunction

  // ------------------------------------------------------------------------
  // driver: item and register channels fed from the plan
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    plan_op_t op;
    bit       in_busy;
    bit       cfg_busy;
    bit       in_go;
    bit       cfg_go;
    int       send_gap;
    int       settle_cnt;

    if (!rst_ni) begin
      in_ch.valid    <= 1'b0;
      in_ch.payload  <= '0;
      cfg_ch.valid   <= 1'b0;
      cfg_ch.payload <= '0;
      calm           <= 1'b0;
      send_gap   = 0;
      settle_cnt = 0;
    end else begin
      in_busy  = in_ch.valid && !in_ch.ready;
      cfg_busy = cfg_ch.valid && !cfg_ch.ready;
      // idle burst after some transactions
      if (in_ch.valid && in_ch.ready && !calm && $urandom_range(0, 3) == 0)
        send_gap = $urandom_range(1, 13);
      if (!in_busy && !cfg_busy) begin
        in_go  = 1'b0;
        cfg_go = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (plan_q.size() != 0) begin
          op = plan_q[0];
          case (op.kind)
            PLAN_ITEM: begin
              in_ch.payload <= op.item;
              in_go = 1'b1;
              void'(plan_q.pop_front());
            end
            PLAN_CFG: begin
              cfg_ch.payload <= op.cfg;
              cfg_go = 1'b1;
              void'(plan_q.pop_front());
            end
            default: begin
              if (results_due != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(plan_q.pop_front());
              end
            end
          endcase
        end
        in_ch.valid  <= in_go;
        cfg_ch.valid <= cfg_go;
      end
      calm <= (plan_q.size() < CALM_OPS);
    end
  end

  // ------------------------------------------------------------------------
  // monitor: tracks every transaction, checks results, drives out ready
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    out_item_t want;
    int        stall_left;
    int        run_left;

    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      results_due  <= 0;
      stall_left = 0;
      run_left   = 0;
      reg_count  = COUNT_RESET;
      reg_start  = START_RESET;
      walk_at    = START_RESET;
      step_result_q.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (step_result_q.size() == 0) begin
          note_fault("unexpected result", '0, out_ch.payload);
        end else begin
          want = step_result_q.pop_front();
          if (out_ch.payload.next_vertex !== want.next_vertex ||
              out_ch.payload.absorbed !== want.absorbed ||
              out_ch.payload.self_loop !== want.self_loop ||
              out_ch.payload.walk_over !== want.walk_over ||
              out_ch.payload.scan_underflow !== want.scan_underflow)
            note_fault("step mismatch", want, out_ch.payload);
        end
      end

      // register write
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.payload.addr)
          CFG_VERTEX_COUNT: reg_count = cfg_ch.payload.data[COUNT_W-1:0];
          CFG_START_VERTEX: reg_start = cfg_ch.payload.data[VERTEX_W-1:0];
          default: begin
          end
        endcase
      end

      // item transaction
      if (in_ch.valid && in_ch.ready) advance_walk(in_ch.payload);

      results_due <= step_result_q.size();

      // receiver stalls in bursts
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 29);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // main sequence: plan, reset, wait for the end, report
  // ------------------------------------------------------------------------
  initial begin : main_proc
    logic [CFG_DATA_W-1:0] count_set [PHASES];
    logic [CFG_DATA_W-1:0] start_data;
    int                    n;
    int                    sel;

    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready   = 1'b0;
    rst_ni         = 1'b0;
    fault_cnt      = 0;
    for (int r = 0; r < MAX_VERTICES; r++)
      for (int c = 0; c < MAX_VERTICES; c++) plan_weight[r][c] = 0;

    // directed: two-vertex walk over rows 0 and 1
    push_cfg(CFG_VERTEX_COUNT, 5'd2);
    push_cfg(CFG_START_VERTEX, 5'd0);
    push_item(CMD_WRITE, 4'd0, 5'd0, 20'h04000, 16'($urandom));
    push_item(CMD_WRITE, 4'd0, 5'd1, 20'h0C000, 16'($urandom));
    push_item(CMD_WRITE, 4'd0, 5'd16, 20'h10000, 16'($urandom));
    push_item(CMD_WRITE, 4'd1, 5'd0, 20'hFFFFF, 16'($urandom));
    push_item(CMD_WRITE, 4'd1, 5'd1, 20'h00000, 16'($urandom));
    push_item(CMD_WRITE, 4'd1, 5'd16, 20'hFFFFF, 16'($urandom));
    // column past the total slot and the unused command are both dropped
    push_item(CMD_WRITE, 4'd15, 5'd31, 20'hA5A5A, 16'($urandom));
    push_item(CMD_UNUSED, 4'($urandom), 5'($urandom), 20'($urandom), 16'($urandom));
    push_item(CMD_WRITE, 4'd9, 5'd16, 20'h00000, 16'($urandom));
    // top fraction jumps to the absorbing vertex, zero fraction runs off the end
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'hFFFF);
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h0000);
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h0001);
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h0000);
    // overweighted row: the scan stops on negative mass
    push_item(CMD_WRITE, 4'd0, 5'd16, 20'h08000, 16'($urandom));
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h8000);
    // count below range, start past the count on a dead vertex
    push_pause();
    push_cfg(CFG_VERTEX_COUNT, 5'd0);
    push_cfg(CFG_START_VERTEX, 5'd9);
    push_item(CMD_RESTART, 4'($urandom), 5'($urandom), 20'($urandom), 16'($urandom));
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'($urandom));
    // count of one, start data with its top bit set
    push_pause();
    push_cfg(CFG_VERTEX_COUNT, 5'd1);
    push_cfg(CFG_START_VERTEX, 5'h11);
    push_item(CMD_RESTART, 4'($urandom), 5'($urandom), 20'($urandom), 16'($urandom));
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h7FFF);
    // moving onto a vertex with zero total ends the walk
    push_item(CMD_WRITE, 4'd1, 5'd16, 20'h00000, 16'($urandom));
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'hFFFF);
    push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom), 16'h1234);

    // random phases over several vertex counts
    count_set[0] = 5'd16;
    count_set[1] = 5'd31;
    count_set[2] = 5'd2;
    count_set[3] = 5'd0;
    count_set[4] = 5'd1;
    count_set[5] = 5'($urandom_range(3, 15));
    count_set[6] = 5'($urandom_range(17, 30));
    count_set[7] = 5'($urandom_range(3, 15));
    count_set[8] = 5'd16;
    for (int p = 0; p < PHASES; p++) begin
      n = (count_set[p] < MIN_VERTICES) ? MIN_VERTICES :
          (count_set[p] > MAX_VERTICES) ? MAX_VERTICES : count_set[p];
      start_data = (p == 1) ? 5'h0F : 5'($urandom);
      push_pause();
      push_cfg(CFG_VERTEX_COUNT, count_set[p]);
      push_cfg(CFG_START_VERTEX, start_data);
      // first phase fills the whole table so no step can see an unwritten word
      if (p == 0)
        for (int r = 0; r < MAX_VERTICES; r++)
          for (int c = 0; c < MAX_VERTICES; c++)
            push_item(CMD_WRITE, 4'(r), 5'(c), {4'($urandom), plan_edge()},
                      16'($urandom));
      // row totals shaped for this count
      for (int r = 0; r < MAX_VERTICES; r++)
        push_item(CMD_WRITE, 4'(r), 5'd16, plan_total(r, n), 16'($urandom));
      push_item(CMD_RESTART, 4'($urandom), 5'($urandom), 20'($urandom), 16'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 72)
          push_item(CMD_STEP, 4'($urandom), 5'($urandom), 20'($urandom),
                    ($urandom_range(0, 9) == 0) ? {16{1'($urandom)}} : 16'($urandom));
        else if (sel < 80)
          push_item(CMD_RESTART, 4'($urandom), 5'($urandom), 20'($urandom),
                    16'($urandom));
        else if (sel < 90)
          push_item(CMD_WRITE, 4'($urandom), 5'($urandom_range(0, 15)),
                    {4'($urandom), plan_edge()}, 16'($urandom));
        else if (sel < 94) begin
          sel = $urandom_range(0, 15);
          push_item(CMD_WRITE, 4'(sel), 5'd16, plan_total(sel, n), 16'($urandom));
        end else if (sel < 97)
          push_item(CMD_UNUSED, 4'($urandom), 5'($urandom), 20'($urandom),
                    16'($urandom));
        else
          push_item(CMD_WRITE, 4'($urandom), 5'($urandom_range(17, 31)),
                    20'($urandom), 16'($urandom));
      end
    end

    // reset, released away from the active edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for the plan to drain and every result to come back
    while (plan_q.size() != 0 || in_ch.valid || cfg_ch.valid || results_due != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (step_result_q.size() != 0)
      $display("%0d step results never arrived", step_result_q.size());
    if (fault_cnt == 0 && step_result_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
